### rtl/wsd_pkg.sv
`timescale 1ns / 1ps

package wsd_pkg;

   localparam int unsigned MAX_LENGTH_LIMIT = 1048576;
   localparam int unsigned LEN_W            = 21;

   localparam logic [LEN_W-1:0] LIMIT_CAP    = LEN_W'(MAX_LENGTH_LIMIT);
   localparam logic [LEN_W-1:0] LIMIT_RESET  = LEN_W'(MAX_LENGTH_LIMIT);

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   localparam logic [2:0] EXT16_LAST = 3'd1;
   localparam logic [2:0] EXT64_LAST = 3'd7;
   localparam logic [2:0] MASK_LAST  = 3'd3;

   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   typedef enum logic [2:0] {
      V_TEXT       = 3'd0,
      V_BINARY     = 3'd1,
      V_PING       = 3'd2,
      V_PONG       = 3'd3,
      V_CLOSE      = 3'd4,
      V_UNFINISHED = 3'd5,
      V_BADOP      = 3'd6,
      V_OVERSIZE   = 3'd7
   } verdict_type;

   typedef enum logic [5:0] {
      PH_HDR0    = 6'b000001,
      PH_HDR1    = 6'b000010,
      PH_EXT16   = 6'b000100,
      PH_EXT64   = 6'b001000,
      PH_MASK    = 6'b010000,
      PH_PAYLOAD = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [7:0]       payload_byte;
      logic             byte_valid;
      logic             frame_done;
      logic [2:0]       verdict;
      logic [LEN_W-1:0] frame_length;
   } result_type;

   typedef struct packed {
      verdict_type verdict;
      logic        fatal;
   } judgement_type;

   function automatic judgement_type judge(input logic [3:0] opcode, input logic fin);
      judgement_type j;
      j.fatal = 1'b1;
      j.verdict = V_BADOP;
      unique case (opcode)
         OP_TEXT: begin
            j.verdict = fin ? V_TEXT : V_UNFINISHED;
            j.fatal = ~fin;
         end
         OP_BINARY: begin
            j.verdict = fin ? V_BINARY : V_UNFINISHED;
            j.fatal = ~fin;
         end
         OP_CLOSE: j.verdict = V_CLOSE;
         OP_PING: begin
            j.verdict = V_PING;
            j.fatal = 1'b0;
         end
         OP_PONG: begin
            j.verdict = V_PONG;
            j.fatal = 1'b0;
         end
         default: j.verdict = V_BADOP;
      endcase
      return j;
   endfunction

endpackage

### rtl/wsd_if.sv
`timescale 1ns / 1ps

interface wsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       restart;

   modport source (output valid, output rx_byte, output restart, input ready);
   modport sink   (input valid, input rx_byte, input restart, output ready);
endinterface

interface wsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  payload_byte;
   logic        byte_valid;
   logic        frame_done;
   logic [2:0]  verdict;
   logic [20:0] frame_length;

   modport source (output valid, output payload_byte, output byte_valid, output frame_done,
                   output verdict, output frame_length, input ready);
   modport sink   (input valid, input payload_byte, input byte_valid, input frame_done,
                   input verdict, input frame_length, output ready);
endinterface

### rtl/wsd_parser.sv
`timescale 1ns / 1ps

module wsd_parser
   import wsd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       rx_byte,
   input  logic             restart,
   input  logic [LEN_W-1:0] limit,
   output logic             res_valid,
   output result_type       res
);

   phase_type        phase_ff, phase_in;
   logic             final_ff, final_in;
   logic [3:0]       opcode_ff, opcode_in;
   logic             mask_ff, mask_in;
   logic [2:0]       count_ff, count_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             big_ff, big_in;
   logic [31:0]      key_ff, key_in;
   logic [LEN_W-1:0] index_ff, index_in;
   logic             dead_ff, dead_in;

   logic             hdr_done;
   logic [LEN_W-1:0] index_next;
   logic [7:0]       key_byte;
   logic [7:0]       data;
   judgement_type    jd;

   assign index_next = index_ff + 1'b1;
   assign jd         = judge(opcode_ff, final_ff);

   always_comb begin
      unique case (index_ff[1:0])
         2'd0: key_byte = key_ff[31:24];
         2'd1: key_byte = key_ff[23:16];
         2'd2: key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
      data = rx_byte ^ (mask_ff ? key_byte : 8'h00);
   end

   always_comb begin
      phase_in  = phase_ff;
      final_in  = final_ff;
      opcode_in = opcode_ff;
      mask_in   = mask_ff;
      count_in  = count_ff;
      len_in    = len_ff;
      big_in    = big_ff;
      key_in    = key_ff;
      index_in  = index_ff;
      dead_in   = dead_ff;
      hdr_done  = 1'b0;
      res_valid = 1'b0;
      res       = '0;
      if (step) begin
         if (restart) begin
            phase_in  = PH_HDR0;
            final_in  = 1'b0;
            opcode_in = '0;
            mask_in   = 1'b0;
            count_in  = '0;
            len_in    = '0;
            big_in    = 1'b0;
            key_in    = '0;
            index_in  = '0;
            dead_in   = 1'b0;
         end else if (!dead_ff) begin
            unique case (phase_ff)
               PH_HDR0: begin
                  final_in  = rx_byte[7];
                  opcode_in = rx_byte[3:0];
                  phase_in  = PH_HDR1;
               end
               PH_HDR1: begin
                  mask_in  = rx_byte[7];
                  count_in = '0;
                  key_in   = '0;
                  big_in   = 1'b0;
                  len_in   = '0;
                  if (rx_byte[6:0] == LEN_EXT16) begin
                     phase_in = PH_EXT16;
                  end else if (rx_byte[6:0] == LEN_EXT64) begin
                     phase_in = PH_EXT64;
                  end else begin
                     len_in = LEN_W'(rx_byte[6:0]);
                     if (rx_byte[7]) begin
                        phase_in = PH_MASK;
                     end else begin
                        hdr_done = 1'b1;
                     end
                  end
               end
               PH_EXT16, PH_EXT64: begin
                  len_in = {len_ff[LEN_W-9:0], rx_byte};
                  big_in = big_ff | (|len_ff[LEN_W-1:LEN_W-8]);
                  if (count_ff != ((phase_ff == PH_EXT16) ? EXT16_LAST : EXT64_LAST)) begin
                     count_in = count_ff + 1'b1;
                  end else begin
                     count_in = '0;
                     if (mask_ff) begin
                        phase_in = PH_MASK;
                     end else begin
                        hdr_done = 1'b1;
                     end
                  end
               end
               PH_MASK: begin
                  key_in = {key_ff[23:0], rx_byte};
                  if (count_ff != MASK_LAST) begin
                     count_in = count_ff + 1'b1;
                  end else begin
                     count_in = '0;
                     hdr_done = 1'b1;
                  end
               end
               PH_PAYLOAD: begin
                  res_valid        = 1'b1;
                  res.payload_byte = data;
                  res.byte_valid   = 1'b1;
                  index_in         = index_next;
                  if (index_next == len_ff) begin
                     res.frame_done   = 1'b1;
                     res.verdict      = jd.verdict;
                     res.frame_length = len_ff;
                     dead_in          = jd.fatal;
                     phase_in         = PH_HDR0;
                     count_in         = '0;
                     index_in         = '0;
                  end
               end
               default: phase_in = PH_HDR0;
            endcase
            if (hdr_done) begin
               if (big_in || (len_in > limit)) begin
                  res_valid      = 1'b1;
                  res.frame_done = 1'b1;
                  res.verdict    = V_OVERSIZE;
                  dead_in        = 1'b1;
                  phase_in       = PH_HDR0;
               end else if (len_in == '0) begin
                  res_valid      = 1'b1;
                  res.frame_done = 1'b1;
                  res.verdict    = jd.verdict;
                  dead_in        = jd.fatal;
                  phase_in       = PH_HDR0;
                  count_in       = '0;
                  index_in       = '0;
               end else begin
                  phase_in = PH_PAYLOAD;
                  index_in = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         final_ff  <= 1'b0;
         opcode_ff <= '0;
         mask_ff   <= 1'b0;
         count_ff  <= '0;
         len_ff    <= '0;
         big_ff    <= 1'b0;
         key_ff    <= '0;
         index_ff  <= '0;
         dead_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         final_ff  <= final_in;
         opcode_ff <= opcode_in;
         mask_ff   <= mask_in;
         count_ff  <= count_in;
         len_ff    <= len_in;
         big_ff    <= big_in;
         key_ff    <= key_in;
         index_ff  <= index_in;
         dead_ff   <= dead_in;
      end
   end

endmodule

### rtl/wsd_out_buf.sv
`timescale 1ns / 1ps

module wsd_out_buf
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       res_valid,
   input  result_type res,
   output logic       space,
   output logic       out_valid,
   output result_type out,
   input  logic       out_ready
);

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;

   assign space     = ~skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out       = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_in       = res;
            skid_valid_in = res_valid;
         end else begin
            main_in       = res;
            main_valid_in = res_valid;
         end
      end else if (res_valid) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

### rtl/websocket_frame_deframer.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload                                                 Transfer
// req_chan  in         rx_byte[7:0], restart                                   valid & ready
// rsp_chan  out        payload_byte, byte_valid, frame_done, verdict, frame_length  valid & ready
// csr       in         csr_wr_data[20:0] (max payload length)                  csr_wr_en
//
// One byte is taken every cycle while the skid entry is empty; each result is registered.
// The parse state and the output register are the only stages; while a result
// waits on rsp_chan.ready a skid entry takes one more result, then the input
// holds until the skid entry drains.
// Synchronous reset clears the parser and empties both output entries.

module websocket_frame_deframer
   import wsd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   wsd_req_if.sink          req_chan,
   wsd_rsp_if.source        rsp_chan,
   input  logic             csr_wr_en,
   input  logic [LEN_W-1:0] csr_wr_data
);

   logic [LEN_W-1:0] limit_ff;
   logic [LEN_W-1:0] limit_eff;
   logic             step;
   logic             space;
   logic             res_valid;
   result_type       res;
   result_type       out;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   assign limit_eff      = (limit_ff > LIMIT_CAP) ? LIMIT_CAP : limit_ff;
   assign req_chan.ready = space;
   assign step           = req_chan.valid & space;

   wsd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rx_byte   (req_chan.rx_byte),
      .restart   (req_chan.restart),
      .limit     (limit_eff),
      .res_valid (res_valid),
      .res       (res)
   );

   wsd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .space     (space),
      .out_valid (rsp_chan.valid),
      .out       (out),
      .out_ready (rsp_chan.ready)
   );

   assign rsp_chan.payload_byte = out.payload_byte;
   assign rsp_chan.byte_valid   = out.byte_valid;
   assign rsp_chan.frame_done   = out.frame_done;
   assign rsp_chan.verdict      = out.verdict;
   assign rsp_chan.frame_length = out.frame_length;

endmodule

### rtl/wsd_checker.sv
`timescale 1ns / 1ps

module wsd_checker
   import wsd_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [7:0]       payload_byte,
   input logic             byte_valid,
   input logic             frame_done,
   input logic [2:0]       verdict,
   input logic [LEN_W-1:0] frame_length
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(payload_byte) && $stable(byte_valid)
         && $stable(frame_done) && $stable(verdict) && $stable(frame_length))
      else $error("result changed while stalled");

   a_rsp_meaning: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (byte_valid || frame_done)
         && (byte_valid || payload_byte == 8'h00)
         && (frame_done || (verdict == V_TEXT && frame_length == '0)))
      else $error("empty or inconsistent result");

   a_oversize: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_done && verdict == V_OVERSIZE |-> !byte_valid && frame_length == '0)
      else $error("oversize verdict carries payload");

   a_length_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_done |-> frame_length <= LIMIT_CAP)
      else $error("frame length beyond limit");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .payload_byte (rsp_chan.payload_byte),
   .byte_valid   (rsp_chan.byte_valid),
   .frame_done   (rsp_chan.frame_done),
   .verdict      (rsp_chan.verdict),
   .frame_length (rsp_chan.frame_length)
);

### test/tb_websocket_frame_deframer.sv
`timescale 1ns / 1ps

module tb_websocket_frame_deframer;
   import wsd_pkg::*;

   typedef enum int {LEN_SHORT, LEN_WIDE16, LEN_WIDE64} len_form_type;

   localparam int WHOLE_FRAME = 32'h7FFF_FFFF;
   localparam logic [LEN_W-1:0] LIMIT_TOP = '1;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [LEN_W-1:0] csr_wr_data;

   wsd_req_if req_chan ();
   wsd_rsp_if rsp_chan ();

   websocket_frame_deframer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Deframer state mirrored from the accepted byte stream
   phase_type        ph;
   logic             fin_bit;
   logic [3:0]       opcode;
   logic             masked;
   logic [2:0]       hdr_count;
   logic [63:0]      decl_len;
   logic [31:0]      mask_key;
   logic [LEN_W-1:0] pay_index;
   logic             link_dead;
   logic [LEN_W-1:0] len_limit;

   result_type unmasked_q[$];

   logic [LEN_W-1:0] limit_setting;
   int burst_left;
   int frame_bytes_sent;
   int fault_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("== FAIL ==");
      $finish;
   end

   function automatic void clear_parse_state();
      ph = PH_HDR0;
      fin_bit = 1'b0;
      opcode = '0;
      masked = 1'b0;
      hdr_count = '0;
      decl_len = '0;
      mask_key = '0;
      pay_index = '0;
      link_dead = 1'b0;
   endfunction

   function automatic verdict_type conclude_frame();
      verdict_type v;
      logic fatal;
      fatal = 1'b1;
      v = V_BADOP;
      case (opcode)
         OP_TEXT: begin
            v = fin_bit ? V_TEXT : V_UNFINISHED;
            fatal = ~fin_bit;
         end
         OP_BINARY: begin
            v = fin_bit ? V_BINARY : V_UNFINISHED;
            fatal = ~fin_bit;
         end
         OP_CLOSE: v = V_CLOSE;
         OP_PING: begin
            v = V_PING;
            fatal = 1'b0;
         end
         OP_PONG: begin
            v = V_PONG;
            fatal = 1'b0;
         end
         default: v = V_BADOP;
      endcase
      if (fatal) link_dead = 1'b1;
      ph = PH_HDR0;
      hdr_count = '0;
      pay_index = '0;
      return v;
   endfunction

   function automatic bit finish_header(output result_type r);
      logic [63:0] cap;
      r = '0;
      cap = (len_limit > LIMIT_CAP) ? 64'(LIMIT_CAP) : 64'(len_limit);
      if (decl_len > cap) begin
         link_dead = 1'b1;
         ph = PH_HDR0;
         r.frame_done = 1'b1;
         r.verdict = V_OVERSIZE;
         return 1'b1;
      end
      if (decl_len == 0) begin
         r.frame_done = 1'b1;
         r.verdict = conclude_frame();
         return 1'b1;
      end
      ph = PH_PAYLOAD;
      pay_index = '0;
      return 1'b0;
   endfunction

   function automatic bit deframe_step(input logic [7:0] b, input logic rs,
                                       output result_type r);
      logic [6:0] len7;
      logic [7:0] d;
      r = '0;
      if (rs) begin
         clear_parse_state();
         return 1'b0;
      end
      if (link_dead) return 1'b0;
      case (ph)
         PH_HDR0: begin
            fin_bit = b[7];
            opcode = b[3:0];
            ph = PH_HDR1;
            return 1'b0;
         end
         PH_HDR1: begin
            masked = b[7];
            len7 = b[6:0];
            decl_len = '0;
            hdr_count = '0;
            mask_key = '0;
            if (len7 == LEN_EXT16) begin
               ph = PH_EXT16;
               return 1'b0;
            end
            if (len7 == LEN_EXT64) begin
               ph = PH_EXT64;
               return 1'b0;
            end
            decl_len = 64'(len7);
            if (masked) begin
               ph = PH_MASK;
               return 1'b0;
            end
            return finish_header(r);
         end
         PH_EXT16, PH_EXT64: begin
            decl_len = {decl_len[55:0], b};
            if (hdr_count != ((ph == PH_EXT16) ? EXT16_LAST : EXT64_LAST)) begin
               hdr_count = hdr_count + 3'd1;
               return 1'b0;
            end
            hdr_count = '0;
            if (masked) begin
               ph = PH_MASK;
               return 1'b0;
            end
            return finish_header(r);
         end
         PH_MASK: begin
            mask_key = {mask_key[23:0], b};
            if (hdr_count != MASK_LAST) begin
               hdr_count = hdr_count + 3'd1;
               return 1'b0;
            end
            hdr_count = '0;
            return finish_header(r);
         end
         PH_PAYLOAD: begin
            d = b;
            if (masked) d = d ^ mask_key[(3 - int'(pay_index[1:0])) * 8 +: 8];
            pay_index = pay_index + 1'b1;
            r.payload_byte = d;
            r.byte_valid = 1'b1;
            if (64'(pay_index) >= decl_len) begin
               r.frame_length = decl_len[LEN_W-1:0];
               r.frame_done = 1'b1;
               r.verdict = conclude_frame();
            end
            return 1'b1;
         end
         default: begin
            ph = PH_HDR0;
            return 1'b0;
         end
      endcase
   endfunction

   function automatic void note_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) $display("%0t: %s", $realtime, msg);
   endfunction

   always @(posedge clock) begin : watch_channels
      result_type want;
      result_type seen;
      bit gives_result;
      if (reset) begin
         clear_parse_state();
         len_limit = LIMIT_RESET;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.payload_byte = rsp_chan.payload_byte;
            seen.byte_valid = rsp_chan.byte_valid;
            seen.frame_done = rsp_chan.frame_done;
            seen.verdict = rsp_chan.verdict;
            seen.frame_length = rsp_chan.frame_length;
            if (unmasked_q.size() == 0) begin
               note_fault($sformatf("unexpected result: byte %02h valid %0d done %0d %s %0d %s %0d",
                  seen.payload_byte, seen.byte_valid, seen.frame_done,
                  "verdict", seen.verdict, "length", seen.frame_length));
            end else begin
               want = unmasked_q.pop_front();
               if (seen.payload_byte !== want.payload_byte
                   || seen.byte_valid !== want.byte_valid
                   || seen.frame_done !== want.frame_done
                   || seen.verdict !== want.verdict
                   || seen.frame_length !== want.frame_length) begin
                  note_fault($sformatf({"mismatch: expected byte %02h valid %0d done %0d",
                     " verdict %0d length %0d, got byte %02h valid %0d done %0d",
                     " verdict %0d length %0d"},
                     want.payload_byte, want.byte_valid, want.frame_done,
                     want.verdict, want.frame_length,
                     seen.payload_byte, seen.byte_valid, seen.frame_done,
                     seen.verdict, seen.frame_length));
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            gives_result = deframe_step(req_chan.rx_byte, req_chan.restart, want);
            if (gives_result) unmasked_q.push_back(want);
         end
         if (csr_wr_en) len_limit = csr_wr_data;
      end
   end

   initial begin : rsp_stalls
      logic [15:0] stall_mask;
      int hold;
      rsp_chan.ready <= 1'b0;
      stall_mask = '1;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold == 0) begin
            hold = $urandom_range(50, 300);
            case ($urandom_range(0, 4))
               0, 1: stall_mask = '1;
               2: stall_mask = 16'($urandom) | 16'h0001;
               3: stall_mask = 16'h5555;
               default: stall_mask = 16'h8001;
            endcase
         end
         hold--;
         rsp_chan.ready <= stall_mask[0];
         stall_mask = {stall_mask[0], stall_mask[15:1]};
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic rs);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid <= 1'b1;
      req_chan.rx_byte <= b;
      req_chan.restart <= rs;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_frame(input logic fin, input logic [3:0] opc, input logic mk,
                             input len_form_type form, input logic [63:0] dlen,
                             input int body, input int cut);
      logic [7:0] bytes[$];
      logic [31:0] key;
      int i;
      key = $urandom;
      bytes.push_back({fin, 3'($urandom), opc});
      case (form)
         LEN_SHORT: bytes.push_back({mk, dlen[6:0]});
         LEN_WIDE16: begin
            bytes.push_back({mk, LEN_EXT16});
            bytes.push_back(dlen[15:8]);
            bytes.push_back(dlen[7:0]);
         end
         default: begin
            bytes.push_back({mk, LEN_EXT64});
            for (i = 7; i >= 0; i--) bytes.push_back(dlen[i*8 +: 8]);
         end
      endcase
      if (mk) for (i = 3; i >= 0; i--) bytes.push_back(key[i*8 +: 8]);
      repeat (body) bytes.push_back(8'($urandom));
      for (i = 0; i < bytes.size() && i < cut; i++) begin
         send_byte(bytes[i], 1'b0);
         frame_bytes_sent++;
      end
   endtask

   task automatic reopen_link(input int noise);
      repeat (noise) send_byte(8'($urandom), 1'b0);
      send_byte(8'($urandom), 1'b1);
   endtask

   task automatic settle_link();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      @(negedge clock);
      while (unmasked_q.size() != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_limit(input logic [LEN_W-1:0] v);
      settle_link();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_setting = v;
   endtask

   function automatic int unsigned usable_limit();
      return (limit_setting > LIMIT_CAP) ? LIMIT_CAP : limit_setting;
   endfunction

   function automatic len_form_type pick_form(input logic [63:0] n);
      if (n <= 125) begin
         case ($urandom_range(0, 3))
            0: return LEN_WIDE16;
            1: return LEN_WIDE64;
            default: return LEN_SHORT;
         endcase
      end
      if (n <= 65535 && $urandom_range(0, 1) == 1) return LEN_WIDE16;
      return LEN_WIDE64;
   endfunction

   function automatic logic [3:0] pick_good_opcode();
      case ($urandom_range(0, 3))
         0: return OP_TEXT;
         1: return OP_BINARY;
         2: return OP_PING;
         default: return OP_PONG;
      endcase
   endfunction

   function automatic logic [3:0] pick_bad_opcode();
      logic [3:0] op;
      do op = 4'($urandom);
      while (op inside {OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG});
      return op;
   endfunction

   task automatic test_data_frames();
      send_frame(1'b1, OP_TEXT, 1'b0, LEN_SHORT, 2, 2, WHOLE_FRAME);
      send_frame(1'b1, OP_BINARY, 1'b1, LEN_SHORT, 5, 5, WHOLE_FRAME);
      send_frame(1'b1, OP_TEXT, 1'b1, LEN_SHORT, 0, 0, WHOLE_FRAME);
      send_frame(1'b1, OP_BINARY, 1'b0, LEN_WIDE16, 3, 3, WHOLE_FRAME);
      send_frame(1'b1, OP_TEXT, 1'b1, LEN_WIDE64, 2, 2, WHOLE_FRAME);
   endtask

   task automatic test_control_frames();
      send_frame(1'b1, OP_PING, 1'b1, LEN_WIDE16, 2, 2, WHOLE_FRAME);
      send_frame(1'b1, OP_PONG, 1'b0, LEN_SHORT, 0, 0, WHOLE_FRAME);
      send_frame(1'b0, OP_PONG, 1'b0, LEN_WIDE64, 1, 1, WHOLE_FRAME);
      send_frame(1'b1, OP_PING, 1'b0, LEN_SHORT, 1, 1, WHOLE_FRAME);
   endtask

   task automatic test_fatal_verdicts();
      send_frame(1'b1, OP_CLOSE, 1'b1, LEN_SHORT, 1, 1, WHOLE_FRAME);
      reopen_link(2);
      send_frame(1'b0, OP_TEXT, 1'b0, LEN_SHORT, 0, 0, WHOLE_FRAME);
      reopen_link(1);
      send_frame(1'b0, OP_BINARY, 1'b1, LEN_SHORT, 2, 2, WHOLE_FRAME);
      reopen_link(0);
      send_frame(1'b1, 4'h0, 1'b0, LEN_SHORT, 1, 1, WHOLE_FRAME);
      reopen_link(2);
      send_frame(1'b1, 4'h3, 1'b0, LEN_SHORT, 0, 0, WHOLE_FRAME);
      reopen_link(1);
      send_frame(1'b1, 4'hF, 1'b1, LEN_SHORT, 1, 1, WHOLE_FRAME);
      reopen_link(0);
   endtask

   task automatic test_limit_settings();
      set_limit('0);
      send_frame(1'b1, OP_BINARY, 1'b0, LEN_SHORT, 0, 0, WHOLE_FRAME);
      send_frame(1'b1, OP_TEXT, 1'b0, LEN_SHORT, 1, 0, WHOLE_FRAME);
      reopen_link(1);
      set_limit(LIMIT_TOP);
      send_frame(1'b1, OP_BINARY, 1'b0, LEN_WIDE64, 64'(LIMIT_CAP) + 1, 0, WHOLE_FRAME);
      reopen_link(1);
      send_frame(1'b1, OP_BINARY, 1'b1, LEN_WIDE64, 64'(LIMIT_CAP), 4, WHOLE_FRAME);
      reopen_link(0);
      send_frame(1'b1, OP_TEXT, 1'b0, LEN_WIDE64, 64'hFF00_0000_0000_0001, 0, WHOLE_FRAME);
      reopen_link(0);
      set_limit(LEN_W'(100));
      send_frame(1'b1, OP_PING, 1'b0, LEN_SHORT, 101, 0, WHOLE_FRAME);
      reopen_link(0);
      send_frame(1'b1, OP_TEXT, 1'b1, LEN_SHORT, 100, 3, WHOLE_FRAME);
      reopen_link(0);
      set_limit(LIMIT_RESET);
      send_frame(1'b1, OP_BINARY, 1'b1, LEN_WIDE16, 65535, 2, WHOLE_FRAME);
      reopen_link(0);
      send_frame(1'b1, OP_BINARY, 1'b0, LEN_WIDE64, 64'(LIMIT_CAP) + 1, 0, WHOLE_FRAME);
      reopen_link(0);
   endtask

   task automatic test_random_traffic();
      int start;
      int pick;
      int unsigned lim;
      int unsigned top;
      logic [63:0] dlen;
      logic [3:0] opc;
      logic fin;
      start = frame_bytes_sent;
      while (frame_bytes_sent - start < 600) begin
         pick = $urandom_range(0, 99);
         lim = usable_limit();
         if (pick < 55) begin
            opc = pick_good_opcode();
            fin = (opc == OP_PING || opc == OP_PONG) ? 1'($urandom) : 1'b1;
            top = (lim < 24) ? lim : 24;
            dlen = 64'($urandom_range(0, top));
            send_frame(fin, opc, 1'($urandom), pick_form(dlen), dlen, int'(dlen),
                       WHOLE_FRAME);
         end else if (pick < 67) begin
            case ($urandom_range(0, 2))
               0: begin
                  opc = OP_CLOSE;
                  fin = 1'b1;
               end
               1: begin
                  opc = $urandom_range(0, 1) ? OP_TEXT : OP_BINARY;
                  fin = 1'b0;
               end
               default: begin
                  opc = pick_bad_opcode();
                  fin = 1'($urandom);
               end
            endcase
            top = (lim < 6) ? lim : 6;
            dlen = 64'($urandom_range(0, top));
            send_frame(fin, opc, 1'($urandom), pick_form(dlen), dlen, int'(dlen),
                       WHOLE_FRAME);
            reopen_link($urandom_range(0, 3));
         end else if (pick < 75) begin
            if ($urandom_range(0, 1) == 1) begin
               dlen = 64'(lim) + 1 + $urandom_range(0, 2);
            end else begin
               dlen = {$urandom, $urandom};
               if (dlen <= 64'(lim)) dlen = 64'(lim) + 1;
            end
            send_frame(1'($urandom), 4'($urandom), 1'($urandom), pick_form(dlen), dlen, 0,
                       WHOLE_FRAME);
            reopen_link($urandom_range(0, 3));
         end else if (pick < 87) begin
            top = (lim < 65535) ? lim : 65535;
            dlen = 64'($urandom_range(0, top));
            send_frame(1'b1, pick_good_opcode(), 1'($urandom), pick_form(dlen), dlen,
                       (dlen < 16) ? int'(dlen) : 16, $urandom_range(1, 16));
            reopen_link(0);
         end else if (pick < 95) begin
            repeat ($urandom_range(1, 6)) begin
               send_byte(8'($urandom), 1'b0);
               frame_bytes_sent++;
            end
            reopen_link(0);
         end else begin
            case ($urandom_range(0, 5))
               0: set_limit('0);
               1: set_limit(LEN_W'($urandom_range(1, 40)));
               2: set_limit(LIMIT_RESET);
               3: set_limit(LIMIT_TOP);
               4: set_limit(LIMIT_CAP - 1'b1);
               default: set_limit(LEN_W'($urandom_range(41, 2000)));
            endcase
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.rx_byte <= '0;
      req_chan.restart <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      limit_setting = LIMIT_RESET;
      burst_left = 0;
      frame_bytes_sent = 0;
      fault_count = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_data_frames();
      test_control_frames();
      test_fatal_verdicts();
      test_limit_settings();
      test_random_traffic();

      settle_link();
      if (fault_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
